// ----- rtl/core/hrd_pkg.sv -----
// Package for the hex record stream decoder: parser phase encoding,
// result record type, character decode functions and record size constant.
// No dependencies.
package hrd_pkg;

  // Number of data pairs carried by one data record.
  localparam int DATA_BYTES_PER_RECORD = 16;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_TYPE1 = 4'd1,
    PH_TYPE2 = 4'd2,
    PH_DADDR = 4'd3,
    PH_DMISC = 4'd4,
    PH_DHIGH = 4'd5,
    PH_DLOW  = 4'd6,
    PH_DCKS  = 4'd7,
    PH_EADDR = 4'd8,
    PH_ECNT1 = 4'd9,
    PH_ECNT2 = 4'd10,
    PH_ESKIP = 4'd11
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [3:0]  byte_offset;
    logic [15:0] record_address;
    logic        last_of_record;
    logic        finished;
  } res_t;

  typedef struct packed {
    logic emit;     // result produced by the current character
    logic stopped;  // end record done, parser frozen until reset
  } par_status_t;

  // Hex digit value; anything outside 0-9 / A-F decodes as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      diff = c - CHAR_UC_A + 8'd10;
    end
    return diff[3:0];
  endfunction

  // Decimal digit value; non-digits count as zero.
  function automatic logic [3:0] dec_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
    end
    return diff[3:0];
  endfunction

endpackage

// ----- rtl/core/hrd_parser.sv -----
// Record parser state machine: consumes one registered character per step
// and forms at most one result. Depends on hrd_pkg.
module hrd_parser
  import hrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_char,
  output par_status_t status,
  output res_t        res
);

  localparam logic [5:0] LAST_CMP = 6'(DATA_BYTES_PER_RECORD);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  char_counter_r, char_counter_nxt;
  logic [7:0]  first_type_char_r, first_type_char_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [15:0] address_accum_r, address_accum_nxt;
  logic [6:0]  skip_count_r, skip_count_nxt;
  logic        stopped_r, stopped_nxt;

  logic [3:0]  hex_v;
  logic [3:0]  dec_v;
  logic [4:0]  cnt_inc;
  logic [5:0]  cnt_sum;
  logic [6:0]  count;
  logic [6:0]  skip_dec;
  logic        emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HUNT;
      char_counter_r    <= '0;
      first_type_char_r <= '0;
      high_nibble_r     <= '0;
      address_accum_r   <= '0;
      skip_count_r      <= '0;
      stopped_r         <= 1'b0;
    end else if (step) begin
      phase_r           <= phase_nxt;
      char_counter_r    <= char_counter_nxt;
      first_type_char_r <= first_type_char_nxt;
      high_nibble_r     <= high_nibble_nxt;
      address_accum_r   <= address_accum_nxt;
      skip_count_r      <= skip_count_nxt;
      stopped_r         <= stopped_nxt;
    end
  end

  always_comb begin
    hex_v    = hex_value(rx_char);
    dec_v    = dec_value(rx_char);
    cnt_inc  = char_counter_r + 5'd1;
    cnt_sum  = {1'b0, char_counter_r} + 6'd1;
    // count = 10 * first digit + second digit, at most 99
    count    = {high_nibble_r, 3'b000} + {2'b00, high_nibble_r, 1'b0} + {3'b000, dec_v};
    skip_dec = skip_count_r - 7'd1;

    phase_nxt           = phase_r;
    char_counter_nxt    = char_counter_r;
    first_type_char_nxt = first_type_char_r;
    high_nibble_nxt     = high_nibble_r;
    address_accum_nxt   = address_accum_r;
    skip_count_nxt      = skip_count_r;
    stopped_nxt         = stopped_r;
    emit                = 1'b0;

    res.data_byte      = 8'd0;
    res.byte_offset    = 4'd0;
    res.record_address = address_accum_r;
    res.last_of_record = 1'b0;
    res.finished       = 1'b0;

    if (!stopped_r) begin
      unique case (phase_r)
        PH_TYPE1: begin
          first_type_char_nxt = rx_char;
          phase_nxt           = PH_TYPE2;
        end
        PH_TYPE2: begin
          char_counter_nxt  = '0;
          address_accum_nxt = '0;
          if (rx_char == CHAR_ZERO && first_type_char_r == CHAR_ONE) begin
            phase_nxt = PH_DADDR;
          end else if (rx_char == CHAR_ZERO && first_type_char_r == CHAR_ZERO) begin
            phase_nxt = PH_EADDR;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DADDR, PH_EADDR: begin
          address_accum_nxt = {address_accum_r[11:0], hex_v};
          char_counter_nxt  = cnt_inc;
          if (cnt_inc >= 5'd4) begin
            char_counter_nxt = '0;
            phase_nxt        = (phase_r == PH_DADDR) ? PH_DMISC : PH_ECNT1;
          end
        end
        PH_DMISC, PH_DCKS: begin
          char_counter_nxt = cnt_inc;
          if (cnt_inc >= 5'd2) begin
            char_counter_nxt = '0;
            phase_nxt        = (phase_r == PH_DMISC) ? PH_DHIGH : PH_HUNT;
          end
        end
        PH_DHIGH: begin
          high_nibble_nxt = hex_v;
          phase_nxt       = PH_DLOW;
        end
        PH_DLOW: begin
          emit            = 1'b1;
          res.data_byte   = {high_nibble_r, hex_v};
          res.byte_offset = char_counter_r[3:0];
          if (cnt_sum >= LAST_CMP) begin
            res.last_of_record = 1'b1;
            char_counter_nxt   = '0;
            phase_nxt          = PH_DCKS;
          end else begin
            char_counter_nxt = cnt_inc;
            phase_nxt        = PH_DHIGH;
          end
        end
        PH_ECNT1: begin
          high_nibble_nxt = dec_v;
          phase_nxt       = PH_ECNT2;
        end
        PH_ECNT2: begin
          skip_count_nxt   = count;
          char_counter_nxt = '0;
          if (count == 7'd0) begin
            emit         = 1'b1;
            res.finished = 1'b1;
            stopped_nxt  = 1'b1;
            phase_nxt    = PH_HUNT;
          end else begin
            phase_nxt = PH_ESKIP;
          end
        end
        PH_ESKIP: begin
          if (char_counter_r == 5'd0) begin
            char_counter_nxt = 5'd1;
          end else begin
            char_counter_nxt = '0;
            skip_count_nxt   = skip_dec;
            if (skip_dec == 7'd0) begin
              emit         = 1'b1;
              res.finished = 1'b1;
              stopped_nxt  = 1'b1;
              phase_nxt    = PH_HUNT;
            end
          end
        end
        default: begin
          phase_nxt = (rx_char == CHAR_COLON) ? PH_TYPE1 : PH_HUNT;
        end
      endcase
    end
  end

  assign status.emit    = emit;
  assign status.stopped = stopped_r;

endmodule

// ----- rtl/core/hrd_out_stage.sv -----
// Result register with valid/ready handshake toward the receiver.
// Depends on hrd_pkg.
module hrd_out_stage
  import hrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_t        res,
  input  logic        out_ready,
  output logic        free,
  output logic        out_valid,
  output res_t        out_res
);

  logic out_valid_r;
  res_t res_r;

  // Slot is free when empty or being drained this cycle.
  assign free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/core/hex_record_stream_decoder.sv -----
// Top level of the hex record stream decoder: input character register,
// record parser and result register. Depends on hrd_pkg, hrd_parser and
// hrd_out_stage.
//
// Usage:
//   Input channel (in_valid / in_ready / in_rx_char) takes one received
//   ASCII character per request. Result channel (out_valid / out_ready and
//   the out_ fields) carries one decoded data byte per hex pair of a data
//   record, or one finish request when an end record completes.
//   A taken character waits in the input register and updates the parser
//   when it advances; its result, if any, is shown on the out_ ports.
//   Throughput: one character per cycle while the result register is free,
//   with the parser update between the input register and the result register.
//   Reset (rst_n low, synchronous) empties both registers and puts the
//   parser back to hunting for a colon, clearing the stopped flag.
//   When the receiver stalls with a result held, the character already in
//   the input register waits; in_ready drops only when that register is
//   full and cannot advance. Characters that yield no result still pass
//   through at full rate while the result register is free.
//   After the finish request the parser ignores every character until
//   reset, but keeps taking them.
module hex_record_stream_decoder
  import hrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_byte_offset,
  output logic [15:0] out_record_address,
  output logic        out_last_of_record,
  output logic        out_finished
);

  logic        in_valid_r;
  logic [7:0]  rx_char_r;
  logic        advance;
  logic        out_free;
  par_status_t par_status;
  res_t        par_res;
  res_t        out_res;

  // Advance the held character whenever the result slot can take its result.
  assign advance  = in_valid_r && out_free;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Hold the character; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_char_r <= in_rx_char;
    end
  end

  hrd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_char (rx_char_r),
    .status  (par_status),
    .res     (par_res)
  );

  hrd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && par_status.emit),
    .res       (par_res),
    .out_ready (out_ready),
    .free      (out_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_data_byte      = out_res.data_byte;
  assign out_byte_offset    = out_res.byte_offset;
  assign out_record_address = out_res.record_address;
  assign out_last_of_record = out_res.last_of_record;
  assign out_finished       = out_res.finished;

`ifndef ASSERT_OFF
  // A frozen parser never produces another result.
  a_no_emit_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    par_status.stopped |-> !par_status.emit)
    else $error("result produced after end record");

  // A shown finish request means the parser has stopped.
  a_finish_implies_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> par_status.stopped)
    else $error("finish shown while parser still running");

  // The last byte of a data record carries the final offset.
  a_last_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_record) |->
      (out_byte_offset == 4'(DATA_BYTES_PER_RECORD - 1) && !out_finished))
    else $error("last byte flagged at wrong offset");
`endif

endmodule
